// ===== sv/brhs_pkg.sv =====
// brhs_pkg: shared types and constants for the bandit restart selector.
// No dependencies.
`default_nettype none
package brhs_pkg;
    localparam logic [15:0] RATE_FAST_UP   = 16'd26214;
    localparam logic [15:0] RATE_FAST_DOWN = 16'd9830;
    localparam logic [15:0] RATE_SLOW      = 16'd3277;
    localparam logic [7:0]  STAG_LIMIT     = 8'd6;
    localparam logic [6:0]  SMALL_GLUE     = 7'd2;

    // Front to back: one finished interval
    typedef struct packed {
        logic [63:0] dsum;
        logic        dsmall_zero;
        logic [23:0] conflicts;
        logic        arm;
    } t_job;
endpackage
`default_nettype wire

// ===== sv/brhs_front.sv =====
// brhs_front: accumulates the histogram and forms interval deltas.
// Depends on brhs_pkg.
`default_nettype none
module brhs_front #(
    parameter int NUM_BINS = 128
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire  [6:0]        i_bin_index,
    input  wire  [31:0]       i_bin_count,
    input  wire               i_last_bin,
    input  wire  [23:0]       i_interval_conflicts,
    input  wire               i_current_arm,
    output logic              o_job_valid,
    output brhs_pkg::t_job    o_job,
    input  wire               i_job_stall
);
    import brhs_pkg::*;

    logic [63:0] r_gsum, r_small, r_pgsum, r_psmall;
    logic [63:0] r_prod;
    logic [31:0] r_cnt;
    logic        r_busy, r_last, r_small_hit;
    logic [23:0] r_conf;
    logic        r_arm;
    logic        r_jv;
    t_job        r_job;
    logic [63:0] n_gsum, n_small;
    logic        in_range;

    // stage 1 registers the product, stage 2 adds it in
    assign o_stall  = r_busy || (r_jv && i_job_stall);
    assign in_range = ({2'b0, i_bin_index} < 9'(NUM_BINS));

    always_comb begin
        n_gsum  = r_gsum + r_prod;
        n_small = r_small + (r_small_hit ? {32'd0, r_cnt} : 64'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_jv <= 1'b0;
            r_gsum <= '0; r_small <= '0; r_pgsum <= '0; r_psmall <= '0;
        end else begin
            if (r_jv && !i_job_stall) r_jv <= 1'b0;
            if (i_valid && !o_stall) begin
                r_busy <= 1'b1;
                r_prod <= {25'd0, ({7'd0, i_bin_count} * {32'd0, i_bin_index})}
                          & {64{in_range}};
                r_cnt  <= i_bin_count;
                r_small_hit <= in_range && (i_bin_index <= SMALL_GLUE);
                r_last <= i_last_bin;
                r_conf <= i_interval_conflicts;
                r_arm  <= i_current_arm;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                if (r_last) begin
                    r_job.dsum        <= n_gsum - r_pgsum;
                    r_job.dsmall_zero <= (n_small == r_psmall);
                    r_job.conflicts   <= r_conf;
                    r_job.arm         <= r_arm;
                    r_jv     <= 1'b1;
                    r_pgsum  <= n_gsum;
                    r_psmall <= n_small;
                    r_gsum   <= '0;
                    r_small  <= '0;
                end else begin
                    r_gsum  <= n_gsum;
                    r_small <= n_small;
                end
            end
        end
    end

    assign o_job_valid = r_jv;
    assign o_job       = r_job;
endmodule
`default_nettype wire

// ===== sv/brhs_back.sv =====
// brhs_back: serial divide, average update, stagnation and arm scan.
// Depends on brhs_pkg.
`default_nettype none
module brhs_back #(
    parameter int NUM_ARMS = 2
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [1:0]        i_active_arms,
    input  wire               i_job_valid,
    input  brhs_pkg::t_job    i_job,
    output logic              o_job_stall,
    output logic              o_valid,
    input  wire               i_stall,
    output logic              o_next_arm,
    output logic              o_explored_new,
    output logic [31:0]       o_reward,
    output logic [7:0]        o_stagnation_count
);
    import brhs_pkg::*;

    localparam int AW = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
    localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_MUL = 3'd2,
                           S_UPD = 3'd3, S_SCAN = 3'd4, S_OUT = 3'd5;

    logic [2:0]  r_state;
    t_job        r_job;
    logic [63:0] r_rem;
    logic [39:0] r_quo;
    logic [5:0]  r_bit;
    logic [31:0] r_reward;
    logic [31:0] r_fast [NUM_ARMS];
    logic [31:0] r_slow [NUM_ARMS];
    logic [31:0] r_pick [NUM_ARMS];
    logic [7:0]  r_stag;
    logic [47:0] r_mf, r_ms;
    logic        r_fup;
    logic [AW:0] r_idx;
    logic [AW-1:0] r_best;
    logic signed [35:0] r_bestp;
    logic        r_unexp;
    logic        r_ov;
    logic        r_onext, r_oexp;
    logic [31:0] r_orew;
    logic [7:0]  r_ostag;

    logic [63:0] div_d, trial;
    logic        arm_ok;
    logic [AW-1:0] ai, si;
    logic [1:0]  scan_n;
    logic signed [35:0] p;
    logic [31:0] fcur, scur, fd, sd, fstep, sstep;
    logic        out_load;

    assign div_d  = (r_job.dsum == 64'd0) ? 64'd1 : r_job.dsum;
    assign trial  = {r_rem[62:0], 1'b0} | 64'(({24'd0, r_job.conflicts, 16'd0} >> r_bit) & 64'd1);
    assign arm_ok = ({31'd0, r_job.arm} < 32'(NUM_ARMS));
    assign ai     = AW'(r_job.arm);
    assign si     = r_idx[AW-1:0];
    assign scan_n = (32'(i_active_arms) < 32'(NUM_ARMS)) ? i_active_arms : 2'(NUM_ARMS);
    assign fcur   = r_fast[ai];
    assign scur   = r_slow[ai];
    assign fd     = (r_reward >= fcur) ? r_reward - fcur : fcur - r_reward;
    assign sd     = (r_reward >= scur) ? r_reward - scur : scur - r_reward;
    assign fstep  = 32'((r_mf + 48'd32768) >> 16);
    assign sstep  = 32'((r_ms + 48'd32768) >> 16);
    assign out_load = (r_state == S_OUT) && !(r_ov && i_stall);

    always_comb begin
        p = 36'sd3 * $signed({4'd0, r_fast[si]}) - $signed({4'd0, r_slow[si]});
        if (!(r_stag > STAG_LIMIT && {{(AW){1'b0}}, r_job.arm} == r_idx)) p = p <<< 1;
    end

    assign o_job_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0; r_stag <= '0; r_fup <= 1'b0;
            for (int k = 0; k < NUM_ARMS; k++) begin
                r_fast[k] <= '0; r_slow[k] <= '0; r_pick[k] <= '0;
            end
        end else begin
            if (out_load) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job; r_rem <= '0; r_quo <= '0; r_bit <= 6'd39;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit per cycle, most significant first
                    if (trial >= div_d) begin
                        r_rem <= trial - div_d;
                        r_quo <= {r_quo[38:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_quo <= {r_quo[38:0], 1'b0};
                    end
                    if (r_bit == 6'd0) r_state <= S_MUL;
                    r_bit <= r_bit - 6'd1;
                end
                S_MUL: begin
                    r_reward <= (r_quo[39:32] != 8'd0) ? 32'hFFFF_FFFF : r_quo[31:0];
                    r_fup    <= 1'b0;
                    r_state  <= S_UPD;
                end
                S_UPD: begin
                    // with r_fup clear the rate products are registered; with r_fup set they are applied
                    if (!r_fup) begin
                        r_mf  <= {16'd0, fd} * {32'd0, ((r_reward > fcur) ? RATE_FAST_UP
                                                                         : RATE_FAST_DOWN)};
                        r_ms  <= {16'd0, sd} * {32'd0, RATE_SLOW};
                        r_fup <= 1'b1;
                    end else begin
                        r_fup <= 1'b0;
                        if (arm_ok) begin
                            if (r_pick[ai] == 32'd0) begin
                                r_fast[ai] <= r_reward; r_slow[ai] <= r_reward;
                            end else begin
                                r_fast[ai] <= (r_reward >= fcur) ? fcur + fstep : fcur - fstep;
                                r_slow[ai] <= (r_reward >= scur) ? scur + sstep : scur - sstep;
                            end
                            if (r_pick[ai] != 32'hFFFF_FFFF) r_pick[ai] <= r_pick[ai] + 32'd1;
                        end
                        if (r_job.dsmall_zero) begin
                            if (r_stag != 8'd255) r_stag <= r_stag + 8'd1;
                        end else r_stag <= '0;
                        r_idx <= '0; r_best <= '0; r_unexp <= 1'b0;
                        r_bestp <= -36'sd262144;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx >= (AW+1)'(scan_n)) r_state <= S_OUT;
                    else if (r_pick[si] == 32'd0) begin
                        r_best <= si; r_unexp <= 1'b1; r_state <= S_OUT;
                    end else begin
                        if (p > r_bestp) begin r_bestp <= p; r_best <= si; end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_OUT: if (out_load) begin
                    r_onext <= r_best[0]; r_oexp <= r_unexp;
                    r_orew <= r_reward; r_ostag <= r_stag; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_next_arm = r_onext;
    assign o_explored_new = r_oexp;
    assign o_reward = r_orew;
    assign o_stagnation_count = r_ostag;
endmodule
`default_nettype wire

// ===== sv/bandit_restart_heuristic_select.sv =====
// bandit_restart_heuristic_select: top level of the bandit restart selector.
// Depends on brhs_pkg, brhs_front, brhs_back.
//
// Usage:
//  Input channel (i_valid/o_stall): one histogram bin per item, ascending.
//  Each bin is multiplied, then accumulated; the front stalls meanwhile.
//  Output channel (o_valid/i_stall): one result per item with last_bin.
//  A final bin hands its interval to the back through a one-entry job
//  register; the back runs a restoring divide (one quotient bit a cycle),
//  saturates the quotient into the reward, updates the averages, scans up
//  to min(active_arms, NUM_ARMS) arms one per cycle, then loads the output
//  register. The front keeps taking bins of the next interval meanwhile
//  until a second interval waits.
//  Reset clears all statistics at once; active_arms resets to 2.
//  While i_stall holds, the result waits in the output register and the
//  back holds its next result, back-pressuring the front in turn.
//  i_cfg_we writes active_arms; write only while idle.
`default_nettype none
module bandit_restart_heuristic_select #(
    parameter int NUM_ARMS = 2,
    parameter int NUM_BINS = 128
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_wdata,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [6:0]  i_bin_index,
    input  wire  [31:0] i_bin_count,
    input  wire         i_last_bin,
    input  wire  [23:0] i_interval_conflicts,
    input  wire         i_current_arm,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_next_arm,
    output logic        o_explored_new,
    output logic [31:0] o_reward,
    output logic [7:0]  o_stagnation_count
);
    import brhs_pkg::*;

    logic [1:0] r_active;
    logic       job_valid, job_stall;
    t_job       job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_active <= 2'd2;
        else if (i_cfg_we) r_active <= i_cfg_wdata;
    end

    brhs_front #(.NUM_BINS(NUM_BINS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_bin_index, .i_bin_count,
        .i_last_bin, .i_interval_conflicts, .i_current_arm,
        .o_job_valid(job_valid), .o_job(job), .i_job_stall(job_stall)
    );

    brhs_back #(.NUM_ARMS(NUM_ARMS)) u_back (
        .i_clk, .i_rst_n, .i_active_arms(r_active),
        .i_job_valid(job_valid), .i_job(job), .o_job_stall(job_stall),
        .o_valid, .i_stall, .o_next_arm, .o_explored_new, .o_reward,
        .o_stagnation_count
    );

    // a stalled result must hold
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable({o_next_arm, o_explored_new,
                                                   o_reward, o_stagnation_count}))
        else $error("result changed under stall");
    // handshake outputs are always known out of reset
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_valid, o_stall}))
        else $error("handshake output unknown");
endmodule
`default_nettype wire
